// ===== src/gpcs_pkg.sv =====
// Shared types, codes and field-update helpers for the GPIO config sequencer.
package gpcs_pkg;

    localparam int PIN_COUNT = 16;
    localparam logic [15:0] VALID_PINS = 16'((32'd1 << PIN_COUNT) - 32'd1);

    // register select codes on the result side
    localparam logic [2:0] SEL_MODE  = 3'd0;
    localparam logic [2:0] SEL_OTYPE = 3'd1;
    localparam logic [2:0] SEL_SPEED = 3'd2;
    localparam logic [2:0] SEL_PULL  = 3'd3;
    localparam logic [2:0] SEL_AFL   = 3'd4;
    localparam logic [2:0] SEL_AFH   = 3'd5;
    localparam logic [2:0] SEL_BSRR  = 3'd6;
    localparam logic [2:0] SEL_NONE  = 3'd7;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_PARAM  = 2'd1;
    localparam logic [1:0] STAT_LOCKED = 2'd2;

    localparam logic [1:0] MODE_IN     = 2'd0;
    localparam logic [1:0] MODE_OUT    = 2'd1;
    localparam logic [1:0] MODE_AF     = 2'd2;
    localparam logic [1:0] MODE_ANALOG = 2'd3;

    localparam logic [1:0] LVL_LOW  = 2'd0;
    localparam logic [1:0] LVL_HIGH = 2'd1;
    localparam logic [1:0] LVL_KEEP = 2'd2;
    localparam logic [1:0] LVL_BAD  = 2'd3;

    localparam int STEP_W = 9;

    // Write steps in issue order; a request enables a subset of them.
    typedef enum logic [STEP_W-1:0] {
        ST_NONE  = 9'b000000001,  // single status-only result
        ST_PRE   = 9'b000000010,  // park (driving target) or first mode write
        ST_BSRR  = 9'b000000100,
        ST_SPEED = 9'b000001000,
        ST_OTYPE = 9'b000010000,
        ST_PULL  = 9'b000100000,
        ST_AFL   = 9'b001000000,
        ST_AFH   = 9'b010000000,
        ST_MODE  = 9'b100000000   // final mode write of a driving target
    } step_t;

    typedef struct packed {
        logic [STEP_W-1:0] steps;
        logic [1:0]        status;
        logic [15:0]       mask;
        logic [1:0]        mode;
        logic              drive;
        logic              ot;
        logic [1:0]        spd;
        logic [1:0]        pul;
        logic [3:0]        af;
        logic              lvl_high;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  sel;
        logic [31:0] data;
        logic [1:0]  status;
        logic        last;
    } res_t;

    // replace the 2-bit field of every masked pin
    function automatic logic [31:0] put2(logic [31:0] r, logic [15:0] m, logic [1:0] v);
        logic [31:0] o;
        o = r;
        for (int p = 0; p < 16; p++) begin
            if (m[p]) begin
                o[2*p +: 2] = v;
            end
        end
        return o;
    endfunction

    // replace the 4-bit field of every masked pin in one af half
    function automatic logic [31:0] put4(logic [31:0] r, logic [7:0] m, logic [3:0] v);
        logic [31:0] o;
        o = r;
        for (int p = 0; p < 8; p++) begin
            if (m[p]) begin
                o[4*p +: 4] = v;
            end
        end
        return o;
    endfunction

endpackage

// ===== src/gpcs_front.sv =====
// Front end: request intake, validation, step planning and command queue.
module gpcs_front import gpcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] pin_mask,
    input  logic        restore_defaults,
    input  logic [1:0]  target_mode,
    input  logic        output_type,
    input  logic [1:0]  slew_speed,
    input  logic [1:0]  pull_select,
    input  logic [3:0]  alt_function,
    input  logic [1:0]  initial_level,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_pop
);

    logic [15:0] locked_reg;
    cmd_t        q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    cmd_t        new_cmd;
    logic [1:0]  lvl;
    logic        do_push;

    always_comb begin
        new_cmd          = '0;
        new_cmd.mask     = pin_mask & VALID_PINS;
        new_cmd.status   = STAT_OK;
        lvl              = initial_level;
        new_cmd.mode     = target_mode;
        new_cmd.ot       = output_type;
        new_cmd.spd      = slew_speed;
        new_cmd.pul      = pull_select;
        new_cmd.af       = alt_function;
        if (restore_defaults) begin
            new_cmd.mode = MODE_IN;
            new_cmd.ot   = 1'b0;
            new_cmd.spd  = 2'd0;
            new_cmd.pul  = 2'd0;
            new_cmd.af   = 4'd0;
            lvl          = LVL_KEEP;
        end
        new_cmd.lvl_high = (lvl == LVL_HIGH);
        new_cmd.drive    = (new_cmd.mode == MODE_OUT) || (new_cmd.mode == MODE_AF);

        if (new_cmd.mask == 16'd0) begin
            new_cmd.steps = ST_NONE;
        end
        else if (lvl == LVL_BAD) begin
            new_cmd.steps  = ST_NONE;
            new_cmd.status = STAT_PARAM;
        end
        else if ((locked_reg & new_cmd.mask) != 16'd0) begin
            new_cmd.steps  = ST_NONE;
            new_cmd.status = STAT_LOCKED;
        end
        else begin
            new_cmd.steps = ST_PRE | ST_SPEED | ST_OTYPE | ST_PULL;
            if (new_cmd.drive) begin
                new_cmd.steps = new_cmd.steps | ST_MODE;
                if (lvl != LVL_KEEP) begin
                    new_cmd.steps = new_cmd.steps | ST_BSRR;
                end
            end
            // af halves are touched on restore or an af target
            if (restore_defaults || (new_cmd.mode == MODE_AF)) begin
                if (new_cmd.mask[7:0] != 8'd0) begin
                    new_cmd.steps = new_cmd.steps | ST_AFL;
                end
                if (new_cmd.mask[15:8] != 8'd0) begin
                    new_cmd.steps = new_cmd.steps | ST_AFH;
                end
            end
        end
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ cmd_pop;
        count_next  = 2'(count_reg + {1'b0, do_push} - {1'b0, cmd_pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_reg <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                locked_reg <= cfg_wdata;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ===== src/gpcs_back.sv =====
// Back end: shadow registers and the step sequencer that issues register writes.
module gpcs_back import gpcs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    input  logic res_full,
    output logic res_push,
    output res_t res
);

    logic              busy_reg, busy_next;
    step_t             step_reg, step_next;
    cmd_t              cmd_reg;
    logic [31:0]       mode_reg, mode_next;
    logic [15:0]       otype_reg, otype_next;
    logic [31:0]       speed_reg, speed_next;
    logic [31:0]       pull_reg, pull_next;
    logic [31:0]       afl_reg, afl_next;
    logic [31:0]       afh_reg, afh_next;

    logic [STEP_W-1:0] low_mask, rem, next_bits, first_bits;
    logic              done, emit_valid, advance, load, fire;
    logic [15:0]       park;
    logic [1:0]        cur;
    logic [15:0]       setb, clrb;

    // pins currently driving in a mode other than the target
    always_comb begin
        park = '0;
        for (int p = 0; p < 16; p++) begin
            cur = mode_reg[2*p +: 2];
            if (cmd_reg.mask[p] && ((cur == MODE_OUT) || (cur == MODE_AF))
                && (cur != cmd_reg.mode)) begin
                park[p] = 1'b1;
            end
        end
    end

    always_comb begin
        low_mask   = STEP_W'((step_reg << 1) - 1);
        rem        = cmd_reg.steps & ~low_mask;
        done       = (rem == '0);
        next_bits  = rem & (~rem + STEP_W'(1));
        first_bits = cmd.steps & (~cmd.steps + STEP_W'(1));
        setb       = cmd_reg.lvl_high ? cmd_reg.mask : 16'd0;
        clrb       = cmd_reg.lvl_high ? 16'd0 : cmd_reg.mask;
    end

    // result of the current step and the shadow value it leaves behind
    always_comb begin
        mode_next  = mode_reg;
        otype_next = otype_reg;
        speed_next = speed_reg;
        pull_next  = pull_reg;
        afl_next   = afl_reg;
        afh_next   = afh_reg;
        emit_valid = 1'b1;
        res.sel    = SEL_NONE;
        res.data   = '0;
        res.status = STAT_OK;
        res.last   = done;
        case (step_reg)
            ST_NONE:
            begin
                res.status = cmd_reg.status;
            end
            ST_PRE:
            begin
                if (cmd_reg.drive) begin
                    mode_next  = put2(mode_reg, park, MODE_IN);
                    emit_valid = (park != 16'd0);
                end
                else begin
                    mode_next = put2(mode_reg, cmd_reg.mask, cmd_reg.mode);
                end
                res.sel  = SEL_MODE;
                res.data = mode_next;
            end
            ST_BSRR:
            begin
                res.sel  = SEL_BSRR;
                res.data = {clrb, setb};
            end
            ST_SPEED:
            begin
                speed_next = put2(speed_reg, cmd_reg.mask, cmd_reg.spd);
                res.sel    = SEL_SPEED;
                res.data   = speed_next;
            end
            ST_OTYPE:
            begin
                otype_next = cmd_reg.ot ? (otype_reg | cmd_reg.mask)
                                        : (otype_reg & ~cmd_reg.mask);
                res.sel    = SEL_OTYPE;
                res.data   = {16'd0, otype_next};
            end
            ST_PULL:
            begin
                pull_next = put2(pull_reg, cmd_reg.mask, cmd_reg.pul);
                res.sel   = SEL_PULL;
                res.data  = pull_next;
            end
            ST_AFL:
            begin
                afl_next = put4(afl_reg, cmd_reg.mask[7:0], cmd_reg.af);
                res.sel  = SEL_AFL;
                res.data = afl_next;
            end
            ST_AFH:
            begin
                afh_next = put4(afh_reg, cmd_reg.mask[15:8], cmd_reg.af);
                res.sel  = SEL_AFH;
                res.data = afh_next;
            end
            ST_MODE:
            begin
                mode_next = put2(mode_reg, cmd_reg.mask, cmd_reg.mode);
                res.sel   = SEL_MODE;
                res.data  = mode_next;
            end
            default:
            begin
                emit_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        fire     = busy_reg && emit_valid && !res_full;
        advance  = busy_reg && (!emit_valid || !res_full);
        res_push = fire;
        load     = !busy_reg || (advance && done);
        cmd_pop  = load && cmd_valid;

        if (cmd_pop) begin
            busy_next = 1'b1;
            step_next = step_t'(first_bits);
        end
        else if (advance && done) begin
            busy_next = 1'b0;
            step_next = step_reg;
        end
        else if (advance) begin
            busy_next = busy_reg;
            step_next = step_t'(next_bits);
        end
        else begin
            busy_next = busy_reg;
            step_next = step_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= ST_NONE;
            mode_reg  <= '0;
            otype_reg <= '0;
            speed_reg <= '0;
            pull_reg  <= '0;
            afl_reg   <= '0;
            afh_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            if (fire)
            begin
                mode_reg  <= mode_next;
                otype_reg <= otype_next;
                speed_reg <= speed_next;
                pull_reg  <= pull_next;
                afl_reg   <= afl_next;
                afh_reg   <= afh_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
    end

endmodule

// ===== src/gpcs_res_q.sv =====
// Two-entry result queue that presents register writes to the consumer.
module gpcs_res_q import gpcs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic res_push,
    input  res_t res,
    output logic res_full,
    output logic empty,
    input  logic pop,
    output res_t head
);

    res_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head     = q_reg[rd_ptr_reg];
    assign do_pop   = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ res_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = 2'(count_reg + {1'b0, res_push} - {1'b0, do_pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

// ===== src/gpio_glitch_free_config_sequencer.sv =====
// The first write of a request passes the command queue, the step sequencer's command register
// and the result queue; a driving target with no pin to park first takes a step that writes nothing.
// Throughput: one write per cycle while the result queue is not full; a request issues one write
// per enabled step, and a driving target with no pin to park adds a step that writes nothing.
// A two-deep command queue lets the next request enter while writes drain.
// Reset (async, active low): all shadows zero (every pin input), no pins locked, queues empty.
module gpio_glitch_free_config_sequencer import gpcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        push,
    output logic        full,
    input  logic [15:0] pin_mask,
    input  logic        restore_defaults,
    input  logic [1:0]  target_mode,
    input  logic        output_type,
    input  logic [1:0]  slew_speed,
    input  logic [1:0]  pull_select,
    input  logic [3:0]  alt_function,
    input  logic [1:0]  initial_level,
    // lock register
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // write side
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  reg_select,
    output logic [31:0] reg_data,
    output logic [1:0]  status,
    output logic        last
);

    // front -> back command item
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    // back -> result queue
    logic res_full;
    logic res_push;
    res_t res;
    res_t head;

    // Front: masks off pins beyond the port, applies the restore override,
    // rejects empty / bad-level / locked requests and plans which write
    // steps the request needs.
    gpcs_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .pin_mask         (pin_mask),
        .restore_defaults (restore_defaults),
        .target_mode      (target_mode),
        .output_type      (output_type),
        .slew_speed       (slew_speed),
        .pull_select      (pull_select),
        .alt_function     (alt_function),
        .initial_level    (initial_level),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .cmd_valid        (cmd_valid),
        .cmd              (cmd),
        .cmd_pop          (cmd_pop)
    );

    // Back: walks the planned steps in order, one write per cycle unless the result queue is full, keeping
    // the shadow registers. The park set is taken from the live mode shadow
    // when its step runs, so earlier requests are fully applied by then.
    gpcs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    // Output queue decouples the sequencer from consumer stalls.
    gpcs_res_q u_res_q
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign reg_select = head.sel;
    assign reg_data   = head.data;
    assign status     = head.status;
    assign last       = head.last;

endmodule
